### hdl/line_edit_erase_kill_buffer_assert.svh
// Assertion macros for the line edit buffer
`ifndef LINE_EDIT_ERASE_KILL_BUFFER_ASSERT_SVH
`define LINE_EDIT_ERASE_KILL_BUFFER_ASSERT_SVH

// Condition holds at every clock edge out of reset
`define LEK_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle
`define LEK_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

### hdl/lek_pkg.sv
// Shared types and constants for the line edit buffer
package lek_pkg;

    localparam int DEPTH = 32;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam logic [7:0] ERASE_RST    = 8'd35;
    localparam logic [7:0] KILL_RST     = 8'd64;
    localparam logic [7:0] LINE_END_RST = 8'd10;

    localparam logic [1:0] CFG_ERASE    = 2'd0;
    localparam logic [1:0] CFG_KILL     = 2'd1;
    localparam logic [1:0] CFG_LINE_END = 2'd2;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_ERASE,
        OP_KILL,
        OP_FLUSH
    } op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DRAIN,
        BK_CLOSE
    } bk_state_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] ch;
    } cmd_t;

    typedef struct packed {
        logic [7:0] erase_char;
        logic [7:0] kill_char;
        logic [7:0] line_end_char;
    } cfg_t;

    typedef struct packed {
        logic          draining;
        logic [CW-1:0] fill;
    } bk_stat_t;

endpackage

### hdl/line_edit_erase_kill_buffer.sv
// Line editor with erase and kill characters: top level
// Ordinary, erase and kill characters: one beat per cycle while the queue has
// room; each passes the four-entry command queue and is applied by the back end.
// A flush of n buffered characters gives n+1 output beats: the n characters, one
// per cycle from the line RAM read port while the output is not stalled, then the line end.
// Input stalls while a flush drains and the queue fills.
// aresetn (synchronous) restores the default codes and empties buffer and queue.
module line_edit_erase_kill_buffer import lek_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_char
    input  logic       s_tuser,   // [0] end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tlast,   // last
    output logic       m_tuser,   // [0] dropped
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

`include "line_edit_erase_kill_buffer_assert.svh"

    logic     q_full;
    logic     q_push;
    cmd_t     q_wr_cmd;
    logic     q_pop;
    logic     q_valid;
    cmd_t     q_rd_cmd;
    cfg_t     cfg;
    bk_stat_t stat;

    lek_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_wr_cmd),
        .cfg       (cfg)
    );

    lek_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_cmd  (q_wr_cmd),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .rd_cmd  (q_rd_cmd)
    );

    lek_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (q_rd_cmd),
        .q_pop    (q_pop),
        .cfg      (cfg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .stat     (stat)
    );

    `LEK_ASSERT_HOLDS(a_fill_bound, stat.fill <= DEPTH_C, "fill count beyond depth")
    `LEK_ASSERT_IMPLIES(a_char_in_drain, m_tvalid && !m_tlast, stat.draining,
        "line character presented outside a drain")
    `LEK_ASSERT_IMPLIES(a_drain_clears, $fell(stat.draining), stat.fill == '0,
        "buffer not empty after line drain")

endmodule

### hdl/lek_ram.sv
// Generic single write port RAM with registered read
module lek_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hdl/lek_front.sv
// Front end: config registers, input beat acceptance and classification
module lek_front import lek_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_char
    input  logic       s_tuser,   // [0] end_of_text
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_cmd,
    output cfg_t       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_ERASE:    cfg_next.erase_char    = cfg_data;
                CFG_KILL:     cfg_next.kill_char     = cfg_data;
                CFG_LINE_END: cfg_next.line_end_char = cfg_data;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.erase_char    <= ERASE_RST;
            cfg_reg.kill_char     <= KILL_RST;
            cfg_reg.line_end_char <= LINE_END_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // line end wins over erase, erase over kill
    always_comb begin
        q_cmd.ch = s_tdata;
        if (s_tuser || s_tdata == cfg_reg.line_end_char) begin
            q_cmd.op = OP_FLUSH;
        end else if (s_tdata == cfg_reg.erase_char) begin
            q_cmd.op = OP_ERASE;
        end else if (s_tdata == cfg_reg.kill_char) begin
            q_cmd.op = OP_KILL;
        end else begin
            q_cmd.op = OP_PUSH;
        end
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

endmodule

### hdl/lek_queue.sv
// Short command queue between front and back ends
module lek_queue import lek_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t wr_cmd,
    output logic full,
    input  logic pop,
    output logic valid,
    output cmd_t rd_cmd
);

    cmd_t             entry_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW-1:0]   rd_ptr_next;
    logic [QCW-1:0]   count_reg;
    logic [QCW-1:0]   count_next;
    logic             do_pop;

    assign full   = (count_reg == QCW'(QDEPTH));
    assign valid  = (count_reg != '0);
    assign rd_cmd = entry_reg[rd_ptr_reg];
    assign do_pop = pop && valid;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

### hdl/lek_back.sv
// Back end: line stack, overflow flag and line drain to the output register
module lek_back import lek_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    input  cmd_t       q_cmd,
    output logic       q_pop,
    input  cfg_t       cfg,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tlast,   // last
    output logic       m_tuser,   // [0] dropped
    output bk_stat_t   stat
);

    bk_state_t     state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic          rv_reg, rv_next;

    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_char_reg, out_char_next;
    logic          out_last_reg, out_last_next;
    logic          out_drop_reg, out_drop_next;

    logic          out_free;
    logic          consume;
    logic          issue;
    logic          ram_we;
    logic          ram_re;
    logic [7:0]    ram_rdata;

    lek_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (fill_reg[AW-1:0]),
        .wdata (q_cmd.ch),
        .re    (ram_re),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign out_free = !out_valid_reg || m_tready;
    // rv_reg: ram_rdata holds a character not yet moved to the output register
    assign consume  = (state_reg == BK_DRAIN) && rv_reg && out_free;
    assign issue    = (state_reg == BK_DRAIN) && (rd_idx_reg != fill_reg)
                      && (!rv_reg || consume);

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        ovf_next       = ovf_reg;
        rd_idx_next    = rd_idx_reg;
        rv_next        = rv_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_re         = issue;
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_drop_next  = out_drop_reg;

        case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    case (q_cmd.op)
                        OP_PUSH: begin
                            if (fill_reg < DEPTH_C) begin
                                ram_we    = 1'b1;
                                fill_next = fill_reg + 1'b1;
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        OP_ERASE: begin
                            if (fill_reg != '0) begin
                                fill_next = fill_reg - 1'b1;
                            end
                        end
                        OP_KILL: begin
                            fill_next = '0;
                        end
                        OP_FLUSH: begin
                            state_next  = BK_DRAIN;
                            rd_idx_next = '0;
                            rv_next     = 1'b0;
                        end
                        default: begin
                            state_next = BK_IDLE;
                        end
                    endcase
                end
            end
            BK_DRAIN: begin
                if (consume) begin
                    out_valid_next = 1'b1;
                    out_char_next  = ram_rdata;
                    out_last_next  = 1'b0;
                    out_drop_next  = ovf_reg;
                end
                if (issue) begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                rv_next = issue || (rv_reg && !consume);
                if (rd_idx_reg == fill_reg && (!rv_reg || consume)) begin
                    state_next = BK_CLOSE;
                end
            end
            BK_CLOSE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_char_next  = cfg.line_end_char;
                    out_last_next  = 1'b1;
                    out_drop_next  = ovf_reg;
                    fill_next      = '0;
                    ovf_next       = 1'b0;
                    state_next     = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            fill_reg      <= '0;
            ovf_reg       <= 1'b0;
            rd_idx_reg    <= '0;
            rv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            ovf_reg       <= ovf_next;
            rd_idx_reg    <= rd_idx_next;
            rv_reg        <= rv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        out_drop_reg <= out_drop_next;
    end

    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = out_char_reg;
    assign m_tlast       = out_last_reg;
    assign m_tuser       = out_drop_reg;
    assign stat.draining = (state_reg != BK_IDLE);
    assign stat.fill     = fill_reg;

endmodule
